### rtl/core/cycle_walk_duplicate_finder_top_macros.svh
// Assertion macros for the duplicate finder top level.
`ifndef CYCLE_WALK_DUPLICATE_FINDER_TOP_MACROS_SVH
`define CYCLE_WALK_DUPLICATE_FINDER_TOP_MACROS_SVH

`ifndef SYNTH
`define CWDF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CWDF_NEVER(lbl, cond, msg) \
    `CWDF_ASSERT(lbl, !(cond), msg)
`else
`define CWDF_ASSERT(lbl, prop, msg)
`define CWDF_NEVER(lbl, cond, msg)
`endif

`endif

### rtl/core/cwdf_pkg.sv
// Shared types and constants for the cycle-walk duplicate finder.
`default_nettype none

package cwdf_pkg;

    localparam int VALUE_W          = 10;
    localparam int STATUS_W         = 2;
    localparam int TDATA_W          = 16;
    localparam int CWDF_MAX_ENTRIES = 1024;

    localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    // Read address source for the value store
    typedef enum logic [1:0] {
        RD_SLOW,
        RD_FAST,
        RD_DATA
    } rd_sel_t;

    typedef struct packed {
        logic    write_item;   // store the incoming element, update flags
        logic    clear_array;  // drop count and flags for the next array
        logic    set_error;    // latch the check status with a zero duplicate
        logic    walk_init;    // slow = fast = 0
        rd_sel_t rd_sel;
        logic    slow_from_rd;
        logic    fast_from_rd;
        logic    slow_zero;    // phase two restart
        logic    set_found;    // latch slow as the duplicate
        logic    push_result;  // move latched result into the output register
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] check_status;
        logic                p1_meet;   // slow matches the data just read
        logic                idx_equal; // slow matches fast
        logic                out_busy;  // output register full and stalled
    } stat_t;

endpackage

`default_nettype wire

### rtl/core/cwdf_datapath.sv
// Datapath: value store, array check, walk indexes and result registers.
`default_nettype none

module cwdf_datapath
    import cwdf_pkg::*;
#(
    parameter int MAX_ENTRIES = CWDF_MAX_ENTRIES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    input  logic [VALUE_W-1:0]  value,
    input  logic                m_tready,
    output stat_t               stat,
    output logic                out_valid,
    output logic [VALUE_W-1:0]  out_dup,
    output logic [STATUS_W-1:0] out_status
);

    localparam int ADDR_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > VALUE_W) ? CNT_W : VALUE_W;

    logic [VALUE_W-1:0]  mem [MAX_ENTRIES];
    logic [VALUE_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0]   rd_addr;

    logic [CNT_W-1:0]    count_reg;
    logic [VALUE_W-1:0]  largest_reg;
    logic                zero_seen_reg;
    logic                overflow_reg;
    logic [VALUE_W-1:0]  slow_reg;
    logic [VALUE_W-1:0]  fast_reg;
    logic [VALUE_W-1:0]  res_dup_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic                out_valid_reg;
    logic [VALUE_W-1:0]  out_dup_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic                store_full;

    assign store_full = (count_reg == CNT_W'(MAX_ENTRIES));

    always_comb
    begin
        case (cmd.rd_sel)
            RD_SLOW: rd_addr = ADDR_W'(slow_reg);
            RD_FAST: rd_addr = ADDR_W'(fast_reg);
            RD_DATA: rd_addr = ADDR_W'(rd_data_reg);
            default: rd_addr = ADDR_W'(slow_reg);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_item && !store_full)
        begin
            mem[count_reg[ADDR_W-1:0]] <= value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        if (overflow_reg)
        begin
            stat.check_status = ST_OVERFLOW;
        end
        else if (zero_seen_reg || (CMP_W'(largest_reg) >= CMP_W'(count_reg)))
        begin
            stat.check_status = ST_RANGE;
        end
        else
        begin
            stat.check_status = ST_FOUND;
        end
        stat.p1_meet   = (slow_reg == rd_data_reg);
        stat.idx_equal = (slow_reg == fast_reg);
        stat.out_busy  = out_valid_reg && !m_tready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            largest_reg   <= '0;
            zero_seen_reg <= 1'b0;
            overflow_reg  <= 1'b0;
            slow_reg      <= '0;
            fast_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_array)
            begin
                count_reg     <= '0;
                largest_reg   <= '0;
                zero_seen_reg <= 1'b0;
                overflow_reg  <= 1'b0;
            end
            else if (cmd.write_item)
            begin
                if (store_full)
                begin
                    overflow_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                if (value == '0)
                begin
                    zero_seen_reg <= 1'b1;
                end
                if (value > largest_reg)
                begin
                    largest_reg <= value;
                end
            end

            if (cmd.walk_init)
            begin
                slow_reg <= '0;
                fast_reg <= '0;
            end
            else
            begin
                if (cmd.slow_zero)
                begin
                    slow_reg <= '0;
                end
                else if (cmd.slow_from_rd)
                begin
                    slow_reg <= rd_data_reg;
                end
                if (cmd.fast_from_rd)
                begin
                    fast_reg <= rd_data_reg;
                end
            end

            if (cmd.push_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.set_error)
        begin
            res_dup_reg    <= '0;
            res_status_reg <= stat.check_status;
        end
        else if (cmd.set_found)
        begin
            res_dup_reg    <= slow_reg;
            res_status_reg <= ST_FOUND;
        end
        if (cmd.push_result)
        begin
            out_dup_reg    <= res_dup_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_dup    = out_dup_reg;
    assign out_status = out_status_reg;

endmodule

`default_nettype wire

### rtl/core/cwdf_ctrl.sv
// Controller: load sequencing, two-phase walk and result hand-off.
`default_nettype none

module cwdf_ctrl
    import cwdf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    input  logic  s_tlast,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [3:0] {
        LOAD,
        DECIDE,
        P1_A,
        P1_B,
        P1_C,
        P1_D,
        P2_INIT,
        P2_CHK,
        P2_B,
        P2_C,
        RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   take;

    assign s_tready = (state_reg == LOAD);
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = RD_SLOW;
        state_next = state_reg;
        case (state_reg)
            LOAD:
            begin
                cmd.write_item = take;
                if (take && s_tlast)
                begin
                    state_next = DECIDE;
                end
            end
            DECIDE:
            begin
                cmd.clear_array = 1'b1;
                if (stat.check_status != ST_FOUND)
                begin
                    cmd.set_error = 1'b1;
                    state_next    = RESULT;
                end
                else
                begin
                    cmd.walk_init = 1'b1;
                    state_next    = P1_A;
                end
            end
            P1_A:
            begin
                cmd.rd_sel = RD_SLOW;
                state_next = P1_B;
            end
            P1_B:
            begin
                cmd.slow_from_rd = 1'b1;
                cmd.rd_sel       = RD_FAST;
                state_next       = P1_C;
            end
            P1_C:
            begin
                // chase the fast pointer a second hop
                cmd.rd_sel = RD_DATA;
                state_next = P1_D;
            end
            P1_D:
            begin
                cmd.fast_from_rd = 1'b1;
                state_next       = stat.p1_meet ? P2_INIT : P1_A;
            end
            P2_INIT:
            begin
                cmd.slow_zero = 1'b1;
                state_next    = P2_CHK;
            end
            P2_CHK:
            begin
                if (stat.idx_equal)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = RESULT;
                end
                else
                begin
                    cmd.rd_sel = RD_SLOW;
                    state_next = P2_B;
                end
            end
            P2_B:
            begin
                cmd.slow_from_rd = 1'b1;
                cmd.rd_sel       = RD_FAST;
                state_next       = P2_C;
            end
            P2_C:
            begin
                cmd.fast_from_rd = 1'b1;
                state_next       = P2_CHK;
            end
            RESULT:
            begin
                // hold until the output register can take the result
                if (!stat.out_busy)
                begin
                    cmd.push_result = 1'b1;
                    state_next      = LOAD;
                end
            end
            default:
            begin
                state_next = LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/cycle_walk_duplicate_finder_top.sv
// Input channel s_*: one array element per request, s_tdata[9:0] = value, s_tlast on the
// final element. Output channel m_*: one result per array, m_tdata[9:0] = duplicate,
// m_tdata[11:10] = status (found, value out of range, too many elements).
// Loading takes one element per cycle. After the final element the DECIDE state checks
// the array, and an error result goes through RESULT into the output register. Otherwise
// the walk runs on the single read port of the value store: each phase-one step makes
// three reads (slow, fast, then the element fast points at) and a compare, and each
// phase-two step compares slow with fast and then reads both; the result follows.
// s_tready is high only while loading; the block takes one array at a time.
// A result waits in the output register while m_tready is low; loading of the next
// array goes on meanwhile, and a later result holds until that register is free.
// Reset clears the element count, flags and walk state and empties the output
// register; the value store is not cleared, and only entries of the current array
// are ever read.
`default_nettype none
`include "cycle_walk_duplicate_finder_top_macros.svh"

module cycle_walk_duplicate_finder_top
    import cwdf_pkg::*;
#(
    parameter int MAX_ENTRIES = CWDF_MAX_ENTRIES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // [9:0] value
    input  logic               s_tlast,   // last element of the array
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata    // [9:0] duplicate, [11:10] status
);

    localparam int PAD_W = TDATA_W - VALUE_W - STATUS_W;

    cmd_t                cmd;
    stat_t               stat;
    logic [VALUE_W-1:0]  out_dup;
    logic [STATUS_W-1:0] out_status;

    cwdf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cwdf_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .value      (s_tdata[VALUE_W-1:0]),
        .m_tready   (m_tready),
        .stat       (stat),
        .out_valid  (m_tvalid),
        .out_dup    (out_dup),
        .out_status (out_status)
    );

    assign m_tdata = {{PAD_W{1'b0}}, out_status, out_dup};

    `CWDF_NEVER(a_status_code, m_tvalid && (out_status != ST_FOUND) && (out_status != ST_RANGE) && (out_status != ST_OVERFLOW), "undefined status code")
    `CWDF_NEVER(a_error_zero_dup, m_tvalid && (out_status != ST_FOUND) && (out_dup != '0), "error result with nonzero duplicate")
    `CWDF_ASSERT(a_last_stops_load, (s_tvalid && s_tready && s_tlast) |=> !s_tready, "request taken right after final element")

endmodule

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the cycle-walk duplicate finder: directed and random arrays.
`timescale 1ns / 1ps

module testbench;
    import cwdf_pkg::*;

    localparam int DEPTH       = CWDF_MAX_ENTRIES;
    localparam int HOLD_CYCLES = 600;
    localparam int QUIET_LIMIT = 40000;
    localparam int TAIL_CYCLES = 8 * DEPTH;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  dup;
    } finding_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;   // [9:0] value
    logic               s_tlast;   // last element of the array
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;   // [9:0] duplicate, [11:10] status

    // Shadow copy of the block state
    logic [VALUE_W-1:0] shadow_store [DEPTH];
    int unsigned        loaded_count;
    logic [VALUE_W-1:0] peak_value;
    bit                 zero_flag;
    bit                 overflow_flag;
    finding_t           pending_findings [$];

    logic [VALUE_W-1:0] array_buf [$];
    int                 src_idle_pct;
    int                 sink_idle_pct;
    int                 elements_sent;
    int                 mismatch_count;
    int                 hold_seq;
    int                 hold_seen;
    int                 hold_left;
    int                 quiet_cycles;

    cycle_walk_duplicate_finder_top #(
        .MAX_ENTRIES(DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [VALUE_W-1:0] floyd_walk();
        logic [VALUE_W-1:0] slow;
        logic [VALUE_W-1:0] fast;
        int                 guard;
        int                 lim;
        lim   = 4 * DEPTH + 8;
        slow  = '0;
        fast  = '0;
        guard = 0;
        do
        begin
            slow = shadow_store[slow];
            fast = shadow_store[shadow_store[fast]];
            guard++;
        end while (slow != fast && guard < lim);
        slow  = '0;
        guard = 0;
        while (slow != fast && guard < lim)
        begin
            slow = shadow_store[slow];
            fast = shadow_store[fast];
            guard++;
        end
        return slow;
    endfunction

    // Update the shadow state with one accepted element; queue a finding on the last one.
    function automatic void absorb_element(logic [VALUE_W-1:0] v, logic is_last);
        finding_t f;
        if (loaded_count < DEPTH)
        begin
            shadow_store[loaded_count[VALUE_W-1:0]] = v;
            loaded_count++;
        end
        else
        begin
            overflow_flag = 1'b1;
        end
        if (v == '0)
            zero_flag = 1'b1;
        if (v > peak_value)
            peak_value = v;
        if (is_last)
        begin
            f.dup = '0;
            if (overflow_flag)
                f.status = ST_OVERFLOW;
            else if (zero_flag || peak_value >= loaded_count)
                f.status = ST_RANGE;
            else
            begin
                f.status = ST_FOUND;
                f.dup    = floyd_walk();
            end
            pending_findings.push_back(f);
            loaded_count  = 0;
            peak_value    = '0;
            zero_flag     = 1'b0;
            overflow_flag = 1'b0;
        end
    endfunction

    task automatic send_element(input logic [VALUE_W-1:0] v, input logic is_last);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(TDATA_W - VALUE_W){1'b0}}, v};
        s_tlast  <= is_last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        absorb_element(v, is_last);
        elements_sent++;
    endtask

    task automatic send_array();
        int i;
        for (i = 0; i < array_buf.size(); i++)
            send_element(array_buf[i], i == array_buf.size() - 1);
    endtask

    // Hold the sender until every queued finding has come out.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_findings.size() != 0)
            @(posedge clk);
    endtask

    task automatic make_random_array();
        int                 n;
        int                 pick;
        int                 kind;
        int                 flaw;
        int                 j;
        int                 k;
        logic [VALUE_W-1:0] t;
        pick = $urandom_range(0, 99);
        if (pick < 85)
            n = $urandom_range(2, 16);
        else if (pick < 98)
            n = $urandom_range(17, 100);
        else
            n = $urandom_range(101, 300);
        kind = $urandom_range(0, 99);
        array_buf.delete();
        if (kind < 45)
        begin
            for (j = 0; j < n; j++)
                array_buf.push_back(VALUE_W'($urandom_range(1, n - 1)));
        end
        else
        begin
            // permutation of 1..n-1 plus one repeat, shuffled
            for (j = 1; j < n; j++)
                array_buf.push_back(VALUE_W'(j));
            array_buf.push_back(VALUE_W'($urandom_range(1, n - 1)));
            for (j = n - 1; j > 0; j--)
            begin
                k            = $urandom_range(0, j);
                t            = array_buf[j];
                array_buf[j] = array_buf[k];
                array_buf[k] = t;
            end
        end
        if (kind >= 80)
        begin
            k    = $urandom_range(0, n - 1);
            flaw = $urandom_range(0, 3);
            if (flaw == 0)
                array_buf[k] = '0;
            else if (flaw == 1)
                array_buf[k] = VALUE_W'($urandom_range(n, 1023));
            else if (flaw == 2)
                array_buf[k] = VALUE_W'($urandom());
            else
            begin
                array_buf.delete();
                array_buf.push_back(VALUE_W'($urandom_range(0, 1023)));
            end
        end
    endtask

    task automatic test_directed();
        array_buf = '{10'd1, 10'd1};
        send_array();
        array_buf = '{10'd1};
        send_array();
        array_buf = '{10'd0, 10'd1};
        send_array();
        array_buf = '{10'd1, 10'd3, 10'd4, 10'd2, 10'd2};
        send_array();
        array_buf = '{10'd3, 10'd1, 10'd3, 10'd4, 10'd2};
        send_array();
        array_buf = '{10'd1, 10'd2};
        send_array();
        array_buf = '{10'd1023, 10'd1};
        send_array();
        // flags must be clear again after the error arrays
        array_buf = '{10'd2, 10'd1, 10'd2};
        send_array();
    endtask

    task automatic run_random_traffic(input int src_pct, input int sink_pct, input int target);
        int start;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        start         = elements_sent;
        while (elements_sent - start < target)
        begin
            make_random_array();
            send_array();
        end
        wait_drain();
    endtask

    // Stall the output for a long stretch while arrays keep coming.
    task automatic test_output_stall();
        int j;
        hold_seq++;
        for (j = 0; j < 8; j++)
        begin
            make_random_array();
            send_array();
        end
        wait_drain();
    endtask

    always @(posedge clk)
    begin
        if (hold_seen != hold_seq)
        begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        finding_t            want;
        logic [VALUE_W-1:0]  got_dup;
        logic [STATUS_W-1:0] got_status;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_dup    = m_tdata[VALUE_W-1:0];
            got_status = m_tdata[VALUE_W +: STATUS_W];
            if (pending_findings.size() == 0)
            begin
                $display("%0t: unexpected result duplicate=%0d status=%0d",
                         $time, got_dup, got_status);
                mismatch_count++;
            end
            else
            begin
                want = pending_findings.pop_front();
                if (got_dup !== want.dup)
                begin
                    $display("%0t: duplicate mismatch expected=%0d actual=%0d",
                             $time, want.dup, got_dup);
                    mismatch_count++;
                end
                if (got_status !== want.status)
                begin
                    $display("%0t: status mismatch expected=%0d actual=%0d",
                             $time, want.status, got_status);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no request accepted for %0d cycles", $time, QUIET_LIMIT);
            $display("** cycle_walk_duplicate_finder_top: FAILED **");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        src_idle_pct   = 25;
        sink_idle_pct  = 49;
        elements_sent  = 0;
        mismatch_count = 0;
        hold_seq       = 0;
        hold_seen      = 0;
        hold_left      = 0;
        quiet_cycles   = 0;
        loaded_count   = 0;
        peak_value     = '0;
        zero_flag      = 1'b0;
        overflow_flag  = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        wait_drain();
        run_random_traffic(25, 49, 250);
        run_random_traffic(49, 25, 250);
        test_output_stall();
        run_random_traffic(0, 0, 180);

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("** cycle_walk_duplicate_finder_top: PASSED **");
        else
            $display("** cycle_walk_duplicate_finder_top: FAILED **");
        $finish;
    end

endmodule
